### rtl/core/ial_pkg.sv
// ----------------------------------------------------------------------------
// ial_pkg
// Shared types and constants of the indexed array list: request actions,
// controller states, and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ial_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int ACT_W = 3;
  localparam int CNT_W = 5;
  localparam int ITEM_W = 32;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [ACT_W-1:0] {
    ACT_GET          = 3'd0,
    ACT_SET          = 3'd1,
    ACT_INSERT       = 3'd2,
    ACT_APPEND       = 3'd3,
    ACT_REMOVE       = 3'd4,
    ACT_REMOVE_VALUE = 3'd5,
    ACT_CLEAR        = 3'd6
  } ial_action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_GET,
    ST_SCAN,
    ST_FINISH
  } ial_state_e;

  typedef struct packed {
    logic load;
    logic rd_pos;
    logic rd_step;
    logic wr_item;
    logic done;
  } ial_cmd_t;

  typedef struct packed {
    ial_action_e act;
    logic        ok;
    logic        rem_zero;
    logic        pend;
  } ial_status_t;

endpackage

`default_nettype wire

### rtl/core/ial_ctrl.sv
// ----------------------------------------------------------------------------
// ial_ctrl
// Request sequencer: accepts a request, checks it, steps the datapath
// through the read, shift or compaction walk and issues the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ial_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire ial_pkg::ial_status_t stat_i,
  output ial_pkg::ial_cmd_t         cmd_o,
  output logic                      busy_o
);

  ial_pkg::ial_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ial_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ial_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ial_pkg::ST_CHECK;
        end
      end
      ial_pkg::ST_CHECK: begin
        if (!stat_i.ok) begin
          cmd_o.done = 1'b1;
          state_d    = ial_pkg::ST_IDLE;
        end else begin
          case (stat_i.act)
            ial_pkg::ACT_GET: begin
              cmd_o.rd_pos = 1'b1;
              state_d      = ial_pkg::ST_GET;
            end
            ial_pkg::ACT_SET: begin
              cmd_o.wr_item = 1'b1;
              cmd_o.done    = 1'b1;
              state_d       = ial_pkg::ST_IDLE;
            end
            ial_pkg::ACT_INSERT, ial_pkg::ACT_APPEND,
            ial_pkg::ACT_REMOVE, ial_pkg::ACT_REMOVE_VALUE: begin
              state_d = ial_pkg::ST_SCAN;
            end
            default: begin
              cmd_o.done = 1'b1;
              state_d    = ial_pkg::ST_IDLE;
            end
          endcase
        end
      end
      ial_pkg::ST_GET: begin
        cmd_o.done = 1'b1;
        state_d    = ial_pkg::ST_IDLE;
      end
      ial_pkg::ST_SCAN: begin
        cmd_o.rd_step = !stat_i.rem_zero;
        if (stat_i.rem_zero && !stat_i.pend) begin
          state_d = ial_pkg::ST_FINISH;
        end
      end
      ial_pkg::ST_FINISH: begin
        cmd_o.wr_item = (stat_i.act == ial_pkg::ACT_INSERT) ||
                        (stat_i.act == ial_pkg::ACT_APPEND);
        cmd_o.done    = 1'b1;
        state_d       = ial_pkg::ST_IDLE;
      end
      default: begin
        state_d = ial_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ial_pkg::ST_IDLE);

endmodule

`default_nettype wire

### rtl/core/ial_datapath.sv
// ----------------------------------------------------------------------------
// ial_datapath
// Entry memory, length and capacity registers, walk pointers and result
// registers. A walk reads one entry per cycle and writes it back, moved by
// one place or compacted, in the following cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ial_datapath #(
  parameter int DEPTH       = ial_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = ial_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire ial_pkg::ial_cmd_t           cmd_i,
  output ial_pkg::ial_status_t             stat_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [ial_pkg::CNT_W-1:0]   cfg_capacity_limit_i,
  input  wire logic [ial_pkg::ACT_W-1:0]   action_i,
  input  wire logic [ial_pkg::CNT_W-1:0]   position_i,
  input  wire logic [ial_pkg::ITEM_W-1:0]  item_value_i,
  output logic                             done_o,
  output logic [ial_pkg::ITEM_W-1:0]       read_value_o,
  output logic [ial_pkg::CNT_W-1:0]        list_length_o,
  output logic                             status_o
);

  localparam int CW = ial_pkg::CNT_W;
  localparam int AW = $clog2(DEPTH);
  localparam int IW = (AW > CW) ? AW : CW;
  localparam int XW = (VALUE_WIDTH > ial_pkg::ITEM_W) ? VALUE_WIDTH : ial_pkg::ITEM_W;

  logic [VALUE_WIDTH-1:0] mem_q [DEPTH];
  logic [VALUE_WIDTH-1:0] rdata_q;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] cap_q;
  logic [CW-1:0] cap_eff;

  ial_pkg::ial_action_e   act_q, act_in;
  logic [CW-1:0]          pos_q, target_q, target_d;
  logic [VALUE_WIDTH-1:0] v_q;
  logic [CW-1:0]          rd_ptr_q, rd_ptr_init;
  logic [CW-1:0]          wr_ptr_q, wr_ptr_init;
  logic [CW-1:0]          rem_q, rem_init;
  logic                   down_q, filt_q, pend_q;

  logic                   ok;
  logic                   mv_we;
  logic                   mem_we, mem_re;
  logic [IW-1:0]          wa_ext, ra_ext;
  logic [VALUE_WIDTH-1:0] mem_wd;
  logic [XW-1:0]          item_ext, rd_ext;

  assign act_in   = ial_pkg::ial_action_e'(action_i);
  assign item_ext = XW'(item_value_i);
  assign rd_ext   = XW'(rdata_q);
  assign cap_eff  = (int'(cap_q) < DEPTH) ? cap_q : CW'(DEPTH);

  // walk setup from the incoming request
  always_comb begin
    target_d    = (act_in == ial_pkg::ACT_APPEND) ? count_q : position_i;
    rd_ptr_init = '0;
    wr_ptr_init = '0;
    rem_init    = '0;
    case (act_in)
      ial_pkg::ACT_INSERT, ial_pkg::ACT_APPEND: begin
        rd_ptr_init = count_q - CW'(1);
        wr_ptr_init = count_q;
        rem_init    = count_q - target_d;
      end
      ial_pkg::ACT_REMOVE: begin
        rd_ptr_init = position_i + CW'(1);
        wr_ptr_init = position_i;
        rem_init    = count_q - position_i - CW'(1);
      end
      ial_pkg::ACT_REMOVE_VALUE: begin
        rem_init = count_q;
      end
      default: begin
        rem_init = '0;
      end
    endcase
  end

  always_comb begin
    case (act_q)
      ial_pkg::ACT_GET, ial_pkg::ACT_SET, ial_pkg::ACT_REMOVE: ok = (pos_q < count_q);
      ial_pkg::ACT_INSERT: ok = (pos_q <= count_q) && (count_q < cap_eff);
      ial_pkg::ACT_APPEND: ok = (count_q < cap_eff);
      ial_pkg::ACT_REMOVE_VALUE, ial_pkg::ACT_CLEAR: ok = 1'b1;
      default: ok = 1'b0;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (ok) begin
      case (act_q)
        ial_pkg::ACT_INSERT, ial_pkg::ACT_APPEND: count_d = count_q + CW'(1);
        ial_pkg::ACT_REMOVE:                      count_d = count_q - CW'(1);
        ial_pkg::ACT_REMOVE_VALUE:                count_d = wr_ptr_q;
        ial_pkg::ACT_CLEAR:                       count_d = '0;
        default:                                  count_d = count_q;
      endcase
    end
  end

  assign stat_o.act      = act_q;
  assign stat_o.ok       = ok;
  assign stat_o.rem_zero = (rem_q == '0);
  assign stat_o.pend     = pend_q;

  // moved entry lands in the cycle after its read; compaction drops matches
  assign mv_we  = pend_q && !(filt_q && (rdata_q == v_q));
  assign mem_we = mv_we || cmd_i.wr_item;
  assign mem_re = cmd_i.rd_pos || cmd_i.rd_step;
  assign wa_ext = IW'(mv_we ? wr_ptr_q : target_q);
  assign ra_ext = IW'(cmd_i.rd_pos ? target_q : rd_ptr_q);
  assign mem_wd = mv_we ? rdata_q : v_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wa_ext[AW-1:0]] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem_q[ra_ext[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q    <= act_in;
      pos_q    <= position_i;
      target_q <= target_d;
      v_q      <= item_ext[VALUE_WIDTH-1:0];
      down_q   <= (act_in == ial_pkg::ACT_INSERT) || (act_in == ial_pkg::ACT_APPEND);
      filt_q   <= (act_in == ial_pkg::ACT_REMOVE_VALUE);
    end
    if (cmd_i.done) begin
      read_value_o  <= ((act_q == ial_pkg::ACT_GET) && ok) ?
                       rd_ext[ial_pkg::ITEM_W-1:0] : '0;
      list_length_o <= count_d;
      status_o      <= !ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_ptr_q <= rd_ptr_init;
      wr_ptr_q <= wr_ptr_init;
      rem_q    <= rem_init;
    end else begin
      if (cmd_i.rd_step) begin
        rd_ptr_q <= down_q ? rd_ptr_q - CW'(1) : rd_ptr_q + CW'(1);
        rem_q    <= rem_q - CW'(1);
      end
      if (mv_we) begin
        wr_ptr_q <= down_q ? wr_ptr_q - CW'(1) : wr_ptr_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= ial_pkg::CAP_RESET;
      pend_q  <= 1'b0;
      done_o  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_capacity_limit_i;
      end
      if (cmd_i.done) begin
        count_q <= count_d;
      end
      pend_q <= cmd_i.rd_step;
      done_o <= cmd_i.done;
    end
  end

endmodule

`default_nettype wire

### rtl/core/indexed_array_list.sv
// ----------------------------------------------------------------------------
// indexed_array_list
// Ordered list of values in a DEPTH-entry memory with a programmable
// capacity limit: get, set, insert, append, remove, remove-by-value, clear.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive action_i, position_i, item_value_i and raise start_i; the
//   transfer happens at a clock edge with start_i high and busy_o low.
//   Result: done_o is high for exactly one cycle with read_value_o,
//   list_length_o and status_o (1 = rejected). The receiver cannot stall.
//   Config: cfg_valid_i with cfg_capacity_limit_i; cfg_ready_o is always
//   high. Write it only while no request is in flight.
// Walk, from request transfer to done_o:
//   set, get, clear and any rejected request need no walk.
//   insert/append: moves N entries, N = length - index.
//   remove at index: moves N entries, N = length - index - 1.
//   remove-by-value: walks all length entries of the list.
//   The walk reads one entry per cycle through the single memory read port.
//   One request at a time; the next may transfer the cycle done_o is high.
// Reset: length is zero, capacity limit is 16; memory contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_array_list #(
  parameter int DEPTH       = ial_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = ial_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic [ial_pkg::ACT_W-1:0]   action_i,
  input  wire logic [ial_pkg::CNT_W-1:0]   position_i,
  input  wire logic [ial_pkg::ITEM_W-1:0]  item_value_i,
  output logic                             done_o,
  output logic [ial_pkg::ITEM_W-1:0]       read_value_o,
  output logic [ial_pkg::CNT_W-1:0]        list_length_o,
  output logic                             status_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [ial_pkg::CNT_W-1:0]   cfg_capacity_limit_i
);

  ial_pkg::ial_cmd_t    cmd;
  ial_pkg::ial_status_t stat;

  assign cfg_ready_o = 1'b1;

  ial_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  ial_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .cfg_we_i            (cfg_valid_i),
    .cfg_capacity_limit_i(cfg_capacity_limit_i),
    .action_i            (action_i),
    .position_i          (position_i),
    .item_value_i        (item_value_i),
    .done_o              (done_o),
    .read_value_o        (read_value_o),
    .list_length_o       (list_length_o),
    .status_o            (status_o)
  );

`ifndef SYNTH
  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request transfer did not make the block busy");

  a_reject_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (read_value_o == '0))
    else $error("rejected request returned nonzero read value");

  a_len_depth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (int'(list_length_o) <= DEPTH))
    else $error("list length beyond memory depth");

  a_single_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");
`endif

endmodule

`default_nettype wire

### test/tb_indexed_array_list.sv
// ----------------------------------------------------------------------------
// tb_indexed_array_list
// Self-checking bench for the indexed array list. Requests go in over the
// start/busy handshake and a behavioral copy of the list predicts each result.
// Results are compared in order as done_o pulses. Directed tests cover the
// empty list, shifting and the capacity corners. Random phases then follow,
// each with its own capacity limit, growing, shrinking or mixing the list.
// ----------------------------------------------------------------------------
module tb_indexed_array_list;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ACT_W = ial_pkg::ACT_W;
  localparam int CNT_W = ial_pkg::CNT_W;
  localparam int ITEM_W = ial_pkg::ITEM_W;
  localparam int LIST_DEPTH = ial_pkg::DEPTH_DEF;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 95;
  localparam int DRAIN_CYCLES = LIST_DEPTH + 8;

  typedef struct packed {
    logic [ITEM_W-1:0] read_value;
    logic [CNT_W-1:0]  length;
    logic              status;
  } list_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [ACT_W-1:0]  action_i = '0;
  logic [CNT_W-1:0]  position_i = '0;
  logic [ITEM_W-1:0] item_value_i = '0;
  logic              done_o;
  logic [ITEM_W-1:0] read_value_o;
  logic [CNT_W-1:0]  list_length_o;
  logic              status_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CNT_W-1:0]  cfg_capacity_limit_i = '0;

  // list mirror
  logic [ITEM_W-1:0] list_entries [LIST_DEPTH];
  int                list_count = 0;
  logic [CNT_W-1:0]  list_cap = ial_pkg::CAP_RESET;

  list_result_t      results_due [$];
  int                mismatches = 0;
  bit                gaps_off = 1'b0;
  logic [ITEM_W-1:0] value_pool [4];

  indexed_array_list u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .action_i            (action_i),
    .position_i          (position_i),
    .item_value_i        (item_value_i),
    .done_o              (done_o),
    .read_value_o        (read_value_o),
    .list_length_o       (list_length_o),
    .status_o            (status_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_capacity_limit_i(cfg_capacity_limit_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic list_result_t apply_list_request(logic [ACT_W-1:0] act,
                                                      logic [CNT_W-1:0] pos,
                                                      logic [ITEM_W-1:0] val);
    list_result_t res;
    int cap;
    int kept;
    int p;
    res.read_value = '0;
    res.status = 1'b0;
    p = int'(pos);
    cap = (list_cap < LIST_DEPTH) ? int'(list_cap) : LIST_DEPTH;
    case (act)
      ial_pkg::ACT_GET: begin
        if (p < list_count) res.read_value = list_entries[p];
        else res.status = 1'b1;
      end
      ial_pkg::ACT_SET: begin
        if (p < list_count) list_entries[p] = val;
        else res.status = 1'b1;
      end
      ial_pkg::ACT_INSERT, ial_pkg::ACT_APPEND: begin
        if (act == ial_pkg::ACT_APPEND) p = list_count;
        if (p > list_count || list_count >= cap) begin
          res.status = 1'b1;
        end else begin
          for (int i = list_count; i > p; i--) list_entries[i] = list_entries[i-1];
          list_entries[p] = val;
          list_count++;
        end
      end
      ial_pkg::ACT_REMOVE: begin
        if (p < list_count) begin
          for (int i = p + 1; i < list_count; i++) list_entries[i-1] = list_entries[i];
          list_count--;
        end else begin
          res.status = 1'b1;
        end
      end
      ial_pkg::ACT_REMOVE_VALUE: begin
        kept = 0;
        for (int i = 0; i < list_count; i++) begin
          if (list_entries[i] != val) begin
            list_entries[kept] = list_entries[i];
            kept++;
          end
        end
        list_count = kept;
      end
      ial_pkg::ACT_CLEAR: begin
        list_count = 0;
      end
      default: begin
        res.status = 1'b1;
      end
    endcase
    res.length = CNT_W'(list_count);
    return res;
  endfunction

  // idle cycles are taken only where the block could accept
  task automatic send_request(logic [ACT_W-1:0] act, logic [CNT_W-1:0] pos,
                              logic [ITEM_W-1:0] val);
    while (!gaps_off && $urandom_range(99) < 35) begin
      start_i <= 1'b0;
      @(posedge clk_i);
      while (busy_o) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    action_i     <= act;
    position_i   <= pos;
    item_value_i <= val;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    results_due.push_back(apply_list_request(act, pos, val));
  endtask

  // only with the list idle
  task automatic set_capacity(logic [CNT_W-1:0] cap);
    start_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (4 + $urandom_range(0, 3)) @(posedge clk_i);
    cfg_valid_i          <= 1'b1;
    cfg_capacity_limit_i <= cap;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    list_cap = cap;
  endtask

  task automatic report_mismatch(string what, list_result_t want, list_result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t %s: exp %h len %0d st %0d, got %h len %0d st %0d",
               $time, what, want.read_value, want.length, want.status,
               got.read_value, got.length, got.status);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    list_result_t got;
    list_result_t want;
    if (rst_ni && done_o) begin
      got.read_value = read_value_o;
      got.length     = list_length_o;
      got.status     = status_o;
      if (results_due.size() == 0) begin
        want = '0;
        report_mismatch("result with none pending", want, got);
      end else begin
        want = results_due.pop_front();
        if (got.read_value !== want.read_value || got.length !== want.length ||
            got.status !== want.status) begin
          report_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  function automatic logic [ACT_W-1:0] choose_action(int mode);
    int r;
    int w_add;
    int w_rem;
    r = $urandom_range(99);
    case (mode)
      0:       begin w_add = 30; w_rem = 10; end
      1:       begin w_add = 8;  w_rem = 34; end
      default: begin w_add = 16; w_rem = 20; end
    endcase
    if (r == 99) return ACT_UNUSED;
    if (r == 98) return ial_pkg::ACT_CLEAR;
    if (r < w_add) return ial_pkg::ACT_APPEND;
    if (r < 2 * w_add) return ial_pkg::ACT_INSERT;
    if (r < 2 * w_add + w_rem) return ial_pkg::ACT_REMOVE;
    if (r < 2 * w_add + w_rem + w_rem / 2) return ial_pkg::ACT_REMOVE_VALUE;
    return (r % 2 == 0) ? ial_pkg::ACT_GET : ial_pkg::ACT_SET;
  endfunction

  function automatic logic [CNT_W-1:0] pick_position();
    if ($urandom_range(9) < 8) return CNT_W'($urandom_range(list_count));
    return CNT_W'($urandom_range(31));
  endfunction

  function automatic logic [ITEM_W-1:0] pick_value();
    if ($urandom_range(9) < 6) return value_pool[$urandom_range(3)];
    return $urandom;
  endfunction

  task automatic test_empty_list();
    send_request(ial_pkg::ACT_GET, 5'd0, 32'h0);
    send_request(ial_pkg::ACT_REMOVE, 5'd0, 32'h0);
    send_request(ial_pkg::ACT_REMOVE_VALUE, 5'd0, 32'h0);
    send_request(ial_pkg::ACT_INSERT, 5'd1, 32'h1);
    send_request(ial_pkg::ACT_SET, 5'd0, 32'hFFFF_FFFF);
  endtask

  task automatic test_shift_and_remove();
    send_request(ial_pkg::ACT_INSERT, 5'd0, 32'hFFFF_FFFF);
    send_request(ial_pkg::ACT_APPEND, 5'd31, 32'h0000_0000);
    send_request(ial_pkg::ACT_INSERT, 5'd1, 32'hA5A5_A5A5);
    send_request(ial_pkg::ACT_INSERT, 5'd3, 32'hFFFF_FFFF);
    send_request(ial_pkg::ACT_GET, 5'd3, 32'h0);
    send_request(ial_pkg::ACT_GET, 5'd4, 32'h0);
    send_request(ial_pkg::ACT_SET, 5'd1, 32'h1234_5678);
    send_request(ACT_UNUSED, 5'd31, 32'hFFFF_FFFF);
    send_request(ial_pkg::ACT_REMOVE_VALUE, 5'd0, 32'hFFFF_FFFF);
    send_request(ial_pkg::ACT_REMOVE, 5'd1, 32'h0);
    send_request(ial_pkg::ACT_GET, 5'd16, 32'h0);
    send_request(ial_pkg::ACT_GET, 5'd0, 32'h0);
    send_request(ial_pkg::ACT_CLEAR, 5'd0, 32'h0);
  endtask

  task automatic test_full_list();
    set_capacity(5'd2);
    send_request(ial_pkg::ACT_APPEND, 5'd0, 32'h5A5A_5A5A);
    send_request(ial_pkg::ACT_APPEND, 5'd0, 32'h8000_0001);
    send_request(ial_pkg::ACT_APPEND, 5'd0, 32'h7FFF_FFFE);
    send_request(ial_pkg::ACT_INSERT, 5'd0, 32'h0F0F_0F0F);
  endtask

  task automatic test_limit_below_length();
    set_capacity(5'd0);
    send_request(ial_pkg::ACT_GET, 5'd1, 32'h0);
    send_request(ial_pkg::ACT_REMOVE, 5'd0, 32'h0);
    send_request(ial_pkg::ACT_APPEND, 5'd0, 32'hDEAD_0000);
    set_capacity(5'd31);
    send_request(ial_pkg::ACT_APPEND, 5'd0, 32'h0000_BEEF);
    send_request(ial_pkg::ACT_INSERT, 5'd31, 32'h0);
  endtask

  task automatic test_random_traffic();
    logic [CNT_W-1:0] cap;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       cap = 5'd16;
        1:       cap = 5'd31;
        2:       cap = CNT_W'($urandom_range(1, 4));
        3:       cap = 5'd0;
        default: cap = CNT_W'($urandom_range(31));
      endcase
      set_capacity(cap);
      for (int k = 0; k < 4; k++) value_pool[k] = $urandom;
      gaps_off = (ph == 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_request(choose_action(ph % 3), pick_position(), pick_value());
      end
    end
    gaps_off = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_shift_and_remove();
    test_full_list();
    test_limit_below_length();
    test_random_traffic();
    start_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule
